>>> rtl/core/sha256_stream_hasher_assert.svh
// ----------------------------------------------------------------------------
// SHA-256 stream hasher assertion macros
// Clocked, reset-qualified wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

// same-cycle property
`define SHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// antecedent, then consequent in the following cycle
`define SHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/shs_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Word types, FIPS 180-4 constants and the round mixing functions.
// ----------------------------------------------------------------------------
`default_nettype none

package shs_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } shs_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } shs_out_t;

  localparam logic [7:0]  PAD_MARK      = 8'h80;
  localparam logic [5:0]  LEN_START     = 6'd56;
  localparam logic [5:0]  LAST_FILL     = 6'd63;
  localparam logic [5:0]  LAST_ROUND    = 6'd63;
  localparam logic [2:0]  LAST_WORD_IDX = 3'd7;
  localparam logic [63:0] BYTE_BITS     = 64'd8;

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Takes a message one byte word at a time and returns its SHA-256 digest as
// eight 32-bit words, word 0 the most significant, then starts afresh for the
// next message. Every 64th byte starts a compression (64 rounds through the
// single round unit, then a fold of the result into the chaining words) during
// which in_stall is high. At end of message the padding bytes go through the
// same byte path at one a cycle (9 to 72 bytes), followed by one or two
// compressions and the eight digest words at one a cycle or slower under
// out_stall. No input is taken until the last digest word has gone.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire shs_pkg::shs_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output shs_pkg::shs_out_t     out_data
);

  import shs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  state_t      state_r, state_nxt;
  logic [511:0] blk_r, blk_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bitlen_r, bitlen_nxt;
  logic [31:0] chain_r [8];
  logic [31:0] chain_nxt [8];
  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [5:0]  rnd_r, rnd_nxt;
  logic        pad_r, pad_nxt;
  logic        mark_r, mark_nxt;
  logic        lenph_r, lenph_nxt;
  logic        final_r, final_nxt;
  logic        out_valid_r, out_valid_nxt;
  shs_out_t    out_data_r, out_data_nxt;

  logic        push_en;
  logic [7:0]  push_byte;
  logic [2:0]  len_sel;
  logic [7:0]  len_byte;
  logic [2:0]  next_idx;
  logic [31:0] sum0;

  logic [31:0] w0, w1, w9, w14, wt, ch, maj, t1, t2;

  assign w0  = blk_r[511:480];
  assign w1  = blk_r[479:448];
  assign w9  = blk_r[223:192];
  assign w14 = blk_r[63:32];
  assign wt  = (rnd_r[5:4] == 2'b00) ? w0
             : w0 + small_sigma0(w1) + w9 + small_sigma1(w14);
  assign ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1  = v_r[7] + big_sigma1(v_r[4]) + ch + ROUND_K[rnd_r] + wt;
  assign t2  = big_sigma0(v_r[0]) + maj;

  assign len_sel  = LAST_WORD_IDX - fill_r[2:0];
  assign len_byte = bitlen_r[{len_sel, 3'b000} +: 8];
  assign next_idx = out_data_r.word_index + 3'd1;
  assign sum0     = chain_r[0] + v_r[0];

  always_comb begin
    state_nxt     = state_r;
    blk_nxt       = blk_r;
    fill_nxt      = fill_r;
    bitlen_nxt    = bitlen_r;
    chain_nxt     = chain_r;
    v_nxt         = v_r;
    rnd_nxt       = rnd_r;
    pad_nxt       = pad_r;
    mark_nxt      = mark_r;
    lenph_nxt     = lenph_r;
    final_nxt     = final_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    push_en       = 1'b0;
    push_byte     = in_data.data_byte;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.byte_present) begin
            push_en    = 1'b1;
            bitlen_nxt = bitlen_r + BYTE_BITS;
          end
          if (in_data.end_of_message) begin
            pad_nxt   = 1'b1;
            mark_nxt  = 1'b0;
            lenph_nxt = 1'b0;
            final_nxt = 1'b0;
          end
          if (in_data.byte_present && fill_r == LAST_FILL) begin
            state_nxt = ST_ROUND;
            v_nxt     = chain_r;
            rnd_nxt   = '0;
          end else if (in_data.end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        push_en = 1'b1;
        if (!mark_r) begin
          push_byte = PAD_MARK;
        end else if (lenph_r || fill_r == LEN_START) begin
          push_byte = len_byte;
          lenph_nxt = 1'b1;
        end else begin
          push_byte = '0;
        end
        mark_nxt = 1'b1;
        if (fill_r == LAST_FILL) begin
          state_nxt = ST_ROUND;
          final_nxt = lenph_r;
          v_nxt     = chain_r;
          rnd_nxt   = '0;
        end
      end
      ST_ROUND: begin
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        blk_nxt  = {blk_r[479:0], wt};
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == LAST_ROUND) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int k = 0; k < 8; k++) begin
          chain_nxt[k] = chain_r[k] + v_r[k];
        end
        if (final_r) begin
          state_nxt                = ST_OUT;
          out_valid_nxt            = 1'b1;
          out_data_nxt.digest_word = sum0;
          out_data_nxt.word_index  = '0;
          out_data_nxt.last_word   = 1'b0;
        end else if (pad_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          if (out_data_r.last_word) begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b0;
            chain_nxt     = HASH_IV;
            fill_nxt      = '0;
            bitlen_nxt    = '0;
            pad_nxt       = 1'b0;
            mark_nxt      = 1'b0;
            lenph_nxt     = 1'b0;
            final_nxt     = 1'b0;
          end else begin
            out_data_nxt.digest_word = chain_r[next_idx];
            out_data_nxt.word_index  = next_idx;
            out_data_nxt.last_word   = (next_idx == LAST_WORD_IDX);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (push_en) begin
      blk_nxt  = {blk_r[503:0], push_byte};
      fill_nxt = fill_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      bitlen_r    <= '0;
      chain_r     <= HASH_IV;
      pad_r       <= 1'b0;
      mark_r      <= 1'b0;
      lenph_r     <= 1'b0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      bitlen_r    <= bitlen_nxt;
      chain_r     <= chain_nxt;
      pad_r       <= pad_nxt;
      mark_r      <= mark_nxt;
      lenph_r     <= lenph_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    v_r   <= v_nxt;
    rnd_r <= rnd_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> rtl/core/shs_checker.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher port checker
// Watches the ports for digest word order, stall holding and input blocking.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sha256_stream_hasher_assert.svh"

module shs_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire shs_pkg::shs_in_t  in_data,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire shs_pkg::shs_out_t out_data
);

  import shs_pkg::*;

  logic out_take;
  logic in_take;

  assign out_take = out_valid && !out_stall;
  assign in_take  = in_valid && !in_stall && in_data.end_of_message;

  `SHS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled digest word changed")

  `SHS_ASSERT(a_no_input_during_out, out_valid |-> in_stall, "input taken while digest pending")

  `SHS_ASSERT_NEXT(a_word_order, out_take && !out_data.last_word, out_valid && out_data.word_index == 3'($past(out_data.word_index) + 3'd1), "digest words out of order")

  `SHS_ASSERT(a_last_flag, out_valid |-> (out_data.last_word == (out_data.word_index == LAST_WORD_IDX)), "last word flag misplaced")

  `SHS_ASSERT_NEXT(a_end_blocks, in_take, in_stall, "end of message did not start padding")

endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (.*);

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Feeds byte words to the hasher: first a short table of known messages, then
// random messages whose lengths favour the padding and block boundaries. Every
// digest word is held to its pinned digest or an independent SHA-256 model
// fed the accepted words. Both ports idle at random, with one calm stretch,
// and the receiver holds off once for a long time so the block backs up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import shs_pkg::*;

  localparam int TOTAL_WORDS  = 400;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 48;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 200;
  localparam int BOUNDARY_LEN [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  localparam logic [31:0] START_CHAIN [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] MIX_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic            pinned;
    logic [0:7][31:0] words;
  } known_digest_t;

  typedef struct packed {
    shs_in_t       item;
    known_digest_t known;
  } stim_row_t;

  localparam logic [255:0] EMPTY_DIGEST =
    256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
  localparam logic [255:0] ABC_DIGEST =
    256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

  localparam int NUM_ROWS = 14;
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{'{8'h00, 1'b0, 1'b1}, '{1'b1, EMPTY_DIGEST}},
    '{'{8'hff, 1'b0, 1'b0}, '{1'b0, 256'd0}},
    '{'{8'h61, 1'b1, 1'b0}, '{1'b0, 256'd0}},
    '{'{8'h62, 1'b1, 1'b0}, '{1'b0, 256'd0}},
    '{'{8'h63, 1'b1, 1'b1}, '{1'b1, ABC_DIGEST}},
    '{'{8'hff, 1'b1, 1'b1}, '{1'b0, 256'd0}},
    '{'{8'h00, 1'b1, 1'b1}, '{1'b0, 256'd0}},
    '{'{8'h5a, 1'b1, 1'b0}, '{1'b0, 256'd0}},
    '{'{8'hff, 1'b0, 1'b0}, '{1'b0, 256'd0}},
    '{'{8'ha5, 1'b0, 1'b1}, '{1'b0, 256'd0}},
    '{'{8'h00, 1'b0, 1'b1}, '{1'b1, EMPTY_DIGEST}},
    '{'{8'h80, 1'b1, 1'b0}, '{1'b0, 256'd0}},
    '{'{8'h01, 1'b1, 1'b0}, '{1'b0, 256'd0}},
    '{'{8'h7f, 1'b1, 1'b1}, '{1'b0, 256'd0}}
  };

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  shs_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  shs_out_t out_data;

  always #2 clk = ~clk;

  sha256_stream_hasher DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  logic [31:0]   chain [8];
  logic [7:0]    msg_block [64];
  int unsigned   fill;
  logic [63:0]   msg_bits;
  shs_out_t      digest_q [$];
  known_digest_t known_digest_q [$];

  int  n_items     = 0;
  int  n_words_out = 0;
  int  n_errors    = 0;
  int  idle_cycles = 0;
  bit  calm        = 1'b0;

  shs_out_t      expected_word;
  known_digest_t pin;

  function automatic logic [31:0] ror(input logic [31:0] x, input int r);
    return (x >> r) | (x << (32 - r));
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 8; i++) chain[i] = START_CHAIN[i];
    fill     = 0;
    msg_bits = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + MIX_K[t] + w[t];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    msg_block[fill] = b;
    fill = fill + 1;
  endfunction

  function automatic void absorb_word(input shs_in_t w, input known_digest_t k);
    logic [63:0] len;
    shs_out_t    r;
    if (w.byte_present) begin
      put_byte(w.data_byte);
      msg_bits = msg_bits + 64'd8;
      if (fill == 64) begin
        compress_block();
        fill = 0;
      end
    end
    if (w.end_of_message) begin
      len = msg_bits;
      put_byte(8'h80);
      if (fill > 56) begin
        while (fill < 64) put_byte(8'h00);
        compress_block();
        fill = 0;
      end
      while (fill < 56) put_byte(8'h00);
      for (int i = 0; i < 8; i++) put_byte(len[63 - 8*i -: 8]);
      compress_block();
      for (int i = 0; i < 8; i++) begin
        r.digest_word = k.pinned ? k.words[i] : chain[i];
        r.word_index  = 3'(i);
        r.last_word   = (i == 7);
        digest_q.push_back(r);
      end
      restart_message();
    end
  endfunction

  initial restart_message();

  always @(posedge clk) begin
    if (rst_n) begin
      idle_cycles = idle_cycles + 1;
      if (in_valid && !in_stall) begin
        idle_cycles = 0;
        pin = in_data.end_of_message ? known_digest_q.pop_front() : '0;
        absorb_word(in_data, pin);
      end
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        n_words_out = n_words_out + 1;
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word %h index %0d", $time,
                   out_data.digest_word, out_data.word_index);
          n_errors = n_errors + 1;
        end else begin
          expected_word = digest_q.pop_front();
          if (out_data.digest_word !== expected_word.digest_word) begin
            $display("%0t: digest_word expected %h got %h", $time,
                     expected_word.digest_word, out_data.digest_word);
            n_errors = n_errors + 1;
          end
          if (out_data.word_index !== expected_word.word_index) begin
            $display("%0t: word_index expected %0d got %0d", $time,
                     expected_word.word_index, out_data.word_index);
            n_errors = n_errors + 1;
          end
          if (out_data.last_word !== expected_word.last_word) begin
            $display("%0t: last_word expected %b got %b", $time,
                     expected_word.last_word, out_data.last_word);
            n_errors = n_errors + 1;
          end
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // receiver: random stalls, one long hold-off
  initial begin
    bit held;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (!held && n_words_out >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !calm && ($urandom_range(99) < 30);
      @(posedge clk);
    end
  end

  task automatic offer_word(input shs_in_t w, input known_digest_t k);
    if (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    if (w.end_of_message) known_digest_q.push_back(k);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (w.byte_present || w.end_of_message) n_items = n_items + 1;
    calm = (n_items >= 200) && (n_items < 320);
  endtask

  initial begin
    int      len;
    int      pick;
    bit      tail_byte;
    shs_in_t w;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < NUM_ROWS; r++)
      offer_word(DIRECTED_ROWS[r].item, DIRECTED_ROWS[r].known);

    while (n_items < TOTAL_WORDS) begin
      pick = $urandom_range(99);
      if (pick < 30)      len = BOUNDARY_LEN[$urandom_range(9)];
      else if (pick < 35) len = $urandom_range(129, 200);
      else                len = $urandom_range(0, 24);
      tail_byte = (len != 0) && ($urandom_range(1) == 1);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(15) == 0) begin
          w.data_byte      = 8'($urandom);
          w.byte_present   = 1'b0;
          w.end_of_message = 1'b0;
          offer_word(w, '0);
        end
        w.data_byte      = 8'($urandom);
        w.byte_present   = 1'b1;
        w.end_of_message = tail_byte && (k == len - 1);
        offer_word(w, '0);
      end
      if (!tail_byte) begin
        w.data_byte      = 8'($urandom);
        w.byte_present   = 1'b0;
        w.end_of_message = 1'b1;
        offer_word(w, '0);
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (digest_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0 && digest_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl/core
rtl/core/shs_pkg.sv
rtl/core/sha256_stream_hasher.sv
rtl/core/shs_checker.sv
tb/tb_top.sv
